/* rtl/unicode_decomposition_lookup_top_assert.svh */
// Assertion macros shared by the lookup checker
`ifndef UNICODE_DECOMPOSITION_LOOKUP_TOP_ASSERT_SVH
`define UNICODE_DECOMPOSITION_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset
`define UDL_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset
`define UDL_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/udl_pkg.sv */
// Shared types and constants of the decomposition lookup
`timescale 1ns / 1ps

package udl_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 65536;
  localparam int MAP_WORDS     = 16384;
  localparam int MAX_MAP_LEN   = 18;
  localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
  localparam int MAP_AW        = 14;
  localparam int COUNT_W       = TABLE_AW + 1;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int ADDR_W  = 16;
  localparam int CP_W    = 21;
  localparam int TYPE_W  = 5;
  localparam int LEN_W   = 5;
  localparam int CFG_W   = 17;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ENTRY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MAP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Type code of a canonical decomposition; every other code is compatibility
  localparam logic [TYPE_W-1:0] TYPE_CANON = 5'd0;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
    logic [CP_W-1:0]   codepoint;
    logic [TYPE_W-1:0] decomp_type;
    logic [MAP_AW-1:0] map_start;
    logic [LEN_W-1:0]  map_len;
    logic [CP_W-1:0]   map_word;
    logic              canonical;
  } udl_in_t;

  typedef struct packed {
    logic [CP_W-1:0] code_out;
    logic            last;
    logic            from_table;
  } udl_out_t;

  // One stored table entry
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [MAP_AW-1:0] start;
    logic [TYPE_W-1:0] dtype;
    logic [CP_W-1:0]   code;
  } udl_entry_t;

  localparam int ENTRY_W = $bits(udl_entry_t);

  // Controller to datapath
  typedef struct packed {
    logic wr_entry;
    logic wr_map;
    logic load_query;
    logic step_lo;
    logic step_hi;
    logic load_emit;
    logic emit_step;
  } udl_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic range_open;
    logic key_lt;
    logic key_gt;
    logic hit_ok;
    logic rem_one;
  } udl_status_t;

endpackage

/* rtl/unicode_decomposition_lookup_top.sv */
// Top level of the Unicode decomposition lookup
//
//   channel   signals                          accepted when
//   input     start, busy, item                start && !busy
//   result    strobe, result                   strobe (one cycle, no back-pressure)
//   config    cfg_valid, cfg_ready, cfg_data   cfg_valid && cfg_ready
//
// Load and unused words never raise busy. A query holds busy while each search probe
// first addresses the entry memory and then compares, at most 17 probes; after a hit,
// a used mapping emits its words back to back, up to 18. The last result word shows
// in the first cycle that busy is low again; the receiver cannot stall, so results
// never wait. rst clears the controller, bounds, pointers and entry count; memories
// stay undefined until loaded.
`timescale 1ns / 1ps

module unicode_decomposition_lookup_top import udl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  udl_in_t          item,
  output logic             strobe,
  output udl_out_t         result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  udl_ctl_t        ctl;
  udl_status_t     status;
  logic            last;
  logic            from_table;
  logic [CP_W-1:0] code_out;

  assign cfg_ready = !busy;

  udl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (item.cmd),
    .status     (status),
    .ctl        (ctl),
    .busy       (busy),
    .strobe     (strobe),
    .last       (last),
    .from_table (from_table)
  );

  udl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sel_table (from_table),
    .status    (status),
    .code_out  (code_out)
  );

  // Pack the result word
  always_comb begin
    result.code_out   = code_out;
    result.last       = last;
    result.from_table = from_table;
  end

endmodule

/* rtl/udl_ram.sv */
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module udl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/udl_datapath.sv */
// Search and emit datapath: bounds, pointers, entry and mapping memories
`timescale 1ns / 1ps

module udl_datapath import udl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  udl_in_t           item,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  input  udl_ctl_t          ctl,
  input  logic              sel_table,
  output udl_status_t       status,
  output logic [CP_W-1:0]   code_out
);

  logic [CFG_W-1:0]   entry_count;
  logic [CP_W-1:0]    cp_q;
  logic               canon_q;
  logic [COUNT_W-1:0] lo;
  logic [COUNT_W-1:0] hi;
  logic [MAP_AW-1:0]  ptr;
  logic [LEN_W-1:0]   rem;

  logic [COUNT_W-1:0] count_sat;
  logic [COUNT_W:0]   mid_sum;
  logic [COUNT_W-1:0] mid;
  logic [ENTRY_W-1:0] entry_rdata;
  udl_entry_t         entry;
  logic [CP_W-1:0]    map_rdata;
  logic [LEN_W-1:0]   len_sat;
  logic               entry_we;
  logic               map_we;

  // Clamp the count to the table size
  assign count_sat = (entry_count > CFG_W'(TABLE_ENTRIES)) ? COUNT_W'(TABLE_ENTRIES)
                                                           : COUNT_W'(entry_count);

  // Probe the middle of the open interval
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[COUNT_W:1];

  // Drop writes beyond either store
  assign entry_we = ctl.wr_entry && ({1'b0, item.address} < (ADDR_W+1)'(TABLE_ENTRIES));
  assign map_we   = ctl.wr_map && ({1'b0, item.address} < (ADDR_W+1)'(MAP_WORDS));

  udl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (item.address[TABLE_AW-1:0]),
    .wdata ({item.map_len, item.map_start, item.decomp_type, item.codepoint}),
    .raddr (mid[TABLE_AW-1:0]),
    .rdata (entry_rdata)
  );

  udl_ram #(.WIDTH(CP_W), .DEPTH(MAP_WORDS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (item.address[MAP_AW-1:0]),
    .wdata (item.map_word),
    .raddr (ptr),
    .rdata (map_rdata)
  );

  assign entry = udl_entry_t'(entry_rdata);

  // Compare the probed key and qualify a hit
  assign len_sat = (entry.len > LEN_W'(MAX_MAP_LEN)) ? LEN_W'(MAX_MAP_LEN) : entry.len;

  always_comb begin
    status.range_open = lo < hi;
    status.key_lt     = entry.code < cp_q;
    status.key_gt     = entry.code > cp_q;
    status.hit_ok     = (entry.len != '0) &&
                        (canon_q == (entry.dtype == TYPE_CANON));
    status.rem_one    = rem == LEN_W'(1);
  end

  // Hold the configured count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_data;
    end
  end

  // Advance bounds and the emit pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      cp_q    <= '0;
      canon_q <= 1'b0;
      lo      <= '0;
      hi      <= '0;
      ptr     <= '0;
      rem     <= '0;
    end else begin
      if (ctl.load_query) begin
        cp_q    <= item.codepoint;
        canon_q <= item.canonical;
        lo      <= '0;
        hi      <= count_sat;
      end
      if (ctl.step_lo) begin
        lo <= mid + COUNT_W'(1);
      end
      if (ctl.step_hi) begin
        hi <= mid;
      end
      if (ctl.load_emit) begin
        ptr <= entry.start;
        rem <= len_sat;
      end
      if (ctl.emit_step) begin
        ptr <= ptr + MAP_AW'(1);
        rem <= rem - LEN_W'(1);
      end
    end
  end

  // Pick the mapping word or the queried code point
  assign code_out = sel_table ? map_rdata : cp_q;

endmodule

/* rtl/udl_ctrl.sv */
// Controller: command decode, search sequencing and result strobes
`timescale 1ns / 1ps

module udl_ctrl import udl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CMD_W-1:0] cmd,
  input  udl_status_t      status,
  output udl_ctl_t         ctl,
  output logic             busy,
  output logic             strobe,
  output logic             last,
  output logic             from_table
);

  typedef enum logic [1:0] {IDLE, SEARCH, COMPARE, EMIT} state_t;

  state_t state, state_next;
  logic   strobe_next;
  logic   last_next;
  logic   from_table_next;

  assign busy = state != IDLE;

  // Decide the next step from state and datapath status
  always_comb begin
    ctl             = '0;
    state_next      = state;
    strobe_next     = 1'b0;
    last_next       = 1'b0;
    from_table_next = 1'b0;
    case (state)
      IDLE: begin
        if (start) begin
          case (cmd)
            CMD_ENTRY: ctl.wr_entry = 1'b1;
            CMD_MAP:   ctl.wr_map   = 1'b1;
            CMD_QUERY: begin
              ctl.load_query = 1'b1;
              state_next     = SEARCH;
            end
            default: ;
          endcase
        end
      end
      SEARCH: begin
        if (status.range_open) begin
          state_next = COMPARE;
        end else begin
          strobe_next = 1'b1;
          last_next   = 1'b1;
          state_next  = IDLE;
        end
      end
      COMPARE: begin
        if (status.key_lt) begin
          ctl.step_lo = 1'b1;
          state_next  = SEARCH;
        end else if (status.key_gt) begin
          ctl.step_hi = 1'b1;
          state_next  = SEARCH;
        end else if (status.hit_ok) begin
          ctl.load_emit = 1'b1;
          state_next    = EMIT;
        end else begin
          strobe_next = 1'b1;
          last_next   = 1'b1;
          state_next  = IDLE;
        end
      end
      EMIT: begin
        ctl.emit_step   = 1'b1;
        strobe_next     = 1'b1;
        from_table_next = 1'b1;
        last_next       = status.rem_one;
        if (status.rem_one) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // Hold state and the registered result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      strobe     <= 1'b0;
      last       <= 1'b0;
      from_table <= 1'b0;
    end else begin
      state      <= state_next;
      strobe     <= strobe_next;
      last       <= last_next;
      from_table <= from_table_next;
    end
  end

endmodule

/* rtl/udl_checker.sv */
// Port-level checker for the decomposition lookup, bound to the top level
`timescale 1ns / 1ps
`include "unicode_decomposition_lookup_top_assert.svh"

module udl_checker import udl_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input udl_in_t          item,
  input logic             strobe,
  input udl_out_t         result
);

  logic query_take;
  logic mid_word;
  logic ident_word;

  assign query_take = start && !busy && (item.cmd == CMD_QUERY);
  assign mid_word   = strobe && !result.last;
  assign ident_word = strobe && !result.from_table;

  // A query raises busy on the next cycle
  `UDL_ASSERT_NEXT(a_query_busy, clk, rst, query_take, busy, "query accepted, busy stayed low")

  // Mapping words stream without gaps until the last one
  `UDL_ASSERT_NEXT(a_emit_contig, clk, rst, mid_word, strobe, "gap inside a mapping result")

  // More words pending means the block stays busy
  `UDL_ASSERT_NOW(a_pending_busy, clk, rst, mid_word, busy, "idle with result words pending")

  // An identity result is always a single word
  `UDL_ASSERT_NOW(a_identity_last, clk, rst, ident_word, result.last, "lone word without last")

endmodule

bind unicode_decomposition_lookup_top udl_checker u_udl_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .strobe (strobe),
  .result (result)
);

/* bench/unicode_decomposition_lookup_top_tb.sv */
// Self-checking bench for the decomposition lookup: directed table, then random load/query traffic
`timescale 1ns / 1ps

module unicode_decomposition_lookup_top_tb;
  import udl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CP_MAX = 1114111;
  localparam int IDLE_PAUSE = 60;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_BUDGET = 410;
  localparam int NUM_PHASES = 9;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_t;

  // One directed step; on config rows the cp column carries the entry count
  typedef struct packed {
    row_kind_t         kind;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [CP_W-1:0]   cp;
    logic [TYPE_W-1:0] dtype;
    logic [MAP_AW-1:0] mstart;
    logic [LEN_W-1:0]  mlen;
    logic [CP_W-1:0]   mword;
    logic              canon;
    logic [CP_W-1:0]   want_cp;
    logic              want_last;
    logic              want_tab;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  udl_in_t          item = '0;
  logic             strobe;
  udl_out_t         result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  // Shadow of the block's contents
  udl_entry_t       ent_mem [TABLE_ENTRIES];
  bit               ent_ok  [TABLE_ENTRIES];
  logic [CP_W-1:0]  map_mem [MAP_WORDS];
  bit               map_ok  [MAP_WORDS];
  logic [CFG_W-1:0] count_reg = '0;

  udl_out_t pending_codes [$];
  udl_out_t head_word;
  int       error_count = 0;
  int       cycle_count = 0;
  int       sent_count = 0;
  int       burst_left = 0;
  bit       no_idle = 1'b0;
  bit       keys_sorted = 1'b1;

  int phase_cnt [NUM_PHASES] = '{1, 2, 40, 65535, 131071, 0, 9, 300, 65536};
  bit phase_sorted [NUM_PHASES] = '{1, 1, 1, 1, 1, 1, 0, 0, 1};

  dir_row_t dir_rows [27] = '{
    // empty table: identity at both code point extremes, then an unused command
    '{ROW_TYPED, CMD_QUERY, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0},
    '{ROW_TYPED, CMD_QUERY, 0, 1114111, 0, 0, 0, 0, 0, 1114111, 1, 0},
    '{ROW_ITEM, CMD_UNUSED, 65535, 1114111, 16, 16383, 18, 1114111, 1, 0, 0, 0},
    // five sorted entries: wrap, longest, empty, oversize length, top key
    '{ROW_ITEM, CMD_ENTRY, 0, 0, 0, 16383, 3, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_ENTRY, 1, 100, 1, 0, 18, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_ENTRY, 2, 200, 0, 40, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_ENTRY, 3, 300, 31, 0, 31, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_ENTRY, 4, 1114111, 17, 16383, 1, 0, 0, 0, 0, 0},
    // mapping word extremes; the out-of-range write must not land on word 0
    '{ROW_ITEM, CMD_MAP, 0, 0, 0, 0, 0, 1114111, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_MAP, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_MAP, 16384, 0, 0, 0, 0, 12345, 0, 0, 0, 0},
    '{ROW_CFG, CMD_ENTRY, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_QUERY, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
    '{ROW_TYPED, CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0},
    '{ROW_ITEM, CMD_QUERY, 0, 100, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_TYPED, CMD_QUERY, 0, 100, 0, 0, 0, 0, 1, 100, 1, 0},
    '{ROW_TYPED, CMD_QUERY, 0, 200, 0, 0, 0, 0, 1, 200, 1, 0},
    '{ROW_ITEM, CMD_QUERY, 0, 300, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_QUERY, 0, 1114111, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_TYPED, CMD_QUERY, 0, 150, 0, 0, 0, 0, 0, 150, 1, 0},
    // break the ordering and search again
    '{ROW_ITEM, CMD_ENTRY, 1, 500, 2, 3, 2, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_QUERY, 0, 500, 0, 0, 0, 0, 0, 0, 0, 0},
    // oversize count saturates to the full table
    '{ROW_CFG, CMD_ENTRY, 0, 131071, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_QUERY, 0, 2000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_QUERY, 0, 1114111, 0, 0, 0, 0, 1, 0, 0, 0},
    '{ROW_CFG, CMD_ENTRY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_TYPED, CMD_QUERY, 0, 300, 0, 0, 0, 0, 0, 300, 1, 0}
  };

  unicode_decomposition_lookup_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .strobe    (strobe),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Effective entry count after saturation
  function automatic int unsigned search_span();
    return (count_reg > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(count_reg);
  endfunction

  function automatic logic [CP_W-1:0] key_at(input int unsigned a);
    return CP_W'(a * 17 + 3);
  endfunction

  // Half-interval search; returns the first unloaded probe, or -1 when done
  function automatic int walk_table(input logic [CP_W-1:0] cp, output bit hit,
                                    output udl_entry_t e);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = search_span();
    hit = 1'b0;
    e = '0;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (!ent_ok[mid]) return int'(mid);
      if (ent_mem[mid].code < cp) begin
        lo = mid + 1;
      end else if (ent_mem[mid].code > cp) begin
        hi = mid;
      end else begin
        hit = 1'b1;
        e = ent_mem[mid];
        return -1;
      end
    end
    return -1;
  endfunction

  // Number of mapping words a query emits; 0 means identity
  function automatic int mapped_len(input bit hit, input udl_entry_t e, input logic canon);
    if (!hit || e.len == 0 || ((e.dtype == TYPE_CANON) != canon)) return 0;
    return (e.len > MAX_MAP_LEN) ? MAX_MAP_LEN : int'(e.len);
  endfunction

  // Queue the decomposition words a query must produce
  function automatic void lookup_decomp(input logic [CP_W-1:0] cp, input logic canon);
    bit         hit;
    udl_entry_t e;
    udl_out_t   r;
    int         n;
    int         k;
    void'(walk_table(cp, hit, e));
    n = mapped_len(hit, e, canon);
    if (n == 0) begin
      r.code_out = cp;
      r.last = 1'b1;
      r.from_table = 1'b0;
      pending_codes.push_back(r);
    end else begin
      for (k = 0; k < n; k++) begin
        r.code_out = map_mem[MAP_AW'(int'(e.start) + k)];
        r.last = (k + 1 == n);
        r.from_table = 1'b1;
        pending_codes.push_back(r);
      end
    end
  endfunction

  function automatic udl_in_t random_word();
    udl_in_t w;
    w.cmd = CMD_QUERY;
    w.address = ADDR_W'($urandom_range(0, 65535));
    w.codepoint = CP_W'($urandom_range(0, CP_MAX));
    w.decomp_type = $urandom_range(0, 1) ? TYPE_CANON
                                          : TYPE_W'($urandom_range(1, 16));
    w.map_start = MAP_AW'($urandom_range(0, MAP_WORDS - 1));
    w.map_len = LEN_W'($urandom_range(0, MAX_MAP_LEN));
    w.map_word = CP_W'($urandom_range(0, CP_MAX));
    w.canonical = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Present one word, hold it until accepted, then update the shadow
  task automatic drive_word(input udl_in_t w, input bit use_want, input udl_out_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_idle ? 0 : $urandom_range(1, 24);
    end else begin
      gap = 0;
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sent_count++;
    case (w.cmd)
      CMD_ENTRY: begin
        ent_mem[w.address] = '{len: w.map_len, start: w.map_start,
                               dtype: w.decomp_type, code: w.codepoint};
        ent_ok[w.address] = 1'b1;
      end
      CMD_MAP: begin
        if (w.address < MAP_WORDS) begin
          map_mem[w.address[MAP_AW-1:0]] = w.map_word;
          map_ok[w.address[MAP_AW-1:0]] = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (use_want) pending_codes.push_back(want);
        else lookup_decomp(w.codepoint, w.canonical);
      end
      default: ;
    endcase
  endtask

  // Load every entry and mapping word the query will touch
  task automatic fill_lookup_path(input logic [CP_W-1:0] cp, input logic canon);
    int         hole;
    int         n;
    int         k;
    bit         hit;
    udl_entry_t e;
    udl_in_t    w;
    hole = walk_table(cp, hit, e);
    while (hole >= 0) begin
      w = random_word();
      w.cmd = CMD_ENTRY;
      w.address = ADDR_W'(hole);
      if (keys_sorted) w.codepoint = key_at(hole);
      drive_word(w, 1'b0, '0);
      hole = walk_table(cp, hit, e);
    end
    n = mapped_len(hit, e, canon);
    for (k = 0; k < n; k++) begin
      if (!map_ok[MAP_AW'(int'(e.start) + k)]) begin
        w = random_word();
        w.cmd = CMD_MAP;
        w.address = ADDR_W'(MAP_AW'(int'(e.start) + k));
        drive_word(w, 1'b0, '0);
      end
    end
  endtask

  task automatic send_item(input udl_in_t w, input bit use_want, input udl_out_t want);
    if (w.cmd == CMD_QUERY) fill_lookup_path(w.codepoint, w.canonical);
    drive_word(w, use_want, want);
  endtask

  // Drop start and hold off until every result is in and the block is quiet
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_codes.size() != 0 || busy) @(negedge clk);
    repeat (IDLE_PAUSE) @(negedge clk);
  endtask

  task automatic write_entry_count(input logic [CFG_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    count_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_codes.size() == 0) begin
        $error("result word with nothing pending: code_out %0d", result.code_out);
        error_count++;
      end else begin
        head_word = pending_codes.pop_front();
        if (result.code_out !== head_word.code_out) begin
          $error("code_out: expected %0d, got %0d", head_word.code_out, result.code_out);
          error_count++;
        end
        if (result.last !== head_word.last) begin
          $error("last: expected %0d, got %0d", head_word.last, result.last);
          error_count++;
        end
        if (result.from_table !== head_word.from_table) begin
          $error("from_table: expected %0d, got %0d", head_word.from_table,
                 result.from_table);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int       r;
    int       phase;
    int       pick;
    int       j;
    int       cnt;
    int       base;
    int       stop;
    int       half;
    bit       paused;
    udl_in_t  w;
    udl_out_t want;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (r = 0; r < 27; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_entry_count(dir_rows[r].cp[CFG_W-1:0]);
      end else begin
        w = '{cmd: dir_rows[r].cmd, address: dir_rows[r].addr, codepoint: dir_rows[r].cp,
              decomp_type: dir_rows[r].dtype, map_start: dir_rows[r].mstart,
              map_len: dir_rows[r].mlen, map_word: dir_rows[r].mword,
              canonical: dir_rows[r].canon};
        want = '{code_out: dir_rows[r].want_cp, last: dir_rows[r].want_last,
                 from_table: dir_rows[r].want_tab};
        send_item(w, dir_rows[r].kind == ROW_TYPED, want);
      end
    end

    // Random phases over several entry counts, sorted and unsorted keys;
    // each phase runs to its share of the word budget, loads included
    phase_cnt[5] = $urandom_range(0, 131071);
    base = sent_count;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      write_entry_count(CFG_W'(phase_cnt[phase]));
      keys_sorted = phase_sorted[phase];
      no_idle = (phase == 2);
      cnt = search_span();
      stop = base + (phase + 1) * (ITEM_BUDGET - base) / NUM_PHASES;
      half = (sent_count + stop) / 2;
      paused = 1'b0;
      while (sent_count < stop) begin
        if (!paused && sent_count >= half) begin
          wait_idle();
          paused = 1'b1;
        end
        w = random_word();
        pick = $urandom_range(0, 99);
        j = (cnt > 0) ? $urandom_range(0, cnt - 1) : 0;
        if (pick < 55) begin
          // aim most queries at stored keys, a few at the code point extremes
          w.cmd = CMD_QUERY;
          if (pick < 30 && cnt > 0) begin
            if (keys_sorted) w.codepoint = key_at(j);
            else if (ent_ok[j]) w.codepoint = ent_mem[j].code;
          end else if (pick < 35) begin
            w.codepoint = pick[0] ? CP_W'(CP_MAX) : '0;
          end
        end else if (pick < 75) begin
          w.cmd = CMD_ENTRY;
          if (cnt > 0 && pick < 70) w.address = ADDR_W'(j);
          if (keys_sorted && pick < 73) w.codepoint = key_at(w.address);
        end else if (pick < 95) begin
          w.cmd = CMD_MAP;
          if (pick < 88) w.address = ADDR_W'($urandom_range(0, MAP_WORDS - 1));
        end else begin
          w.cmd = CMD_UNUSED;
        end
        send_item(w, 1'b0, '0);
      end
    end

    wait_idle();
    if (error_count == 0 && pending_codes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/udl_pkg.sv
rtl/udl_ram.sv
rtl/udl_datapath.sv
rtl/udl_ctrl.sv
rtl/unicode_decomposition_lookup_top.sv
rtl/udl_checker.sv
bench/unicode_decomposition_lookup_top_tb.sv
